FILE: design/olir_pkg.sv
// Shared types and constants for the ordered list insert/remove unit.
`timescale 1ns / 1ps

package olir_pkg;

    // Fixed field widths of the request and response beats.
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 7;

    // Number of cell taps merged by one first-stage OR group on the read path.
    localparam int TAP_GROUP = 8;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_GET    = 3'd4
    } t_op;

    // Action broadcast to every cell of the chain in the same cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_WRITE,
        ACT_SHIFT_UP,
        ACT_SHIFT_DOWN
    } t_cell_act;

    // Request beat payload.
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] item;
    } t_req;

    // Response beat payload.
    typedef struct packed {
        logic               ok;
        logic [ITEM_W-1:0]  read_item;
        logic [COUNT_W-1:0] count;
    } t_rsp;

endpackage

FILE: design/olir_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps

interface olir_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/olir_cell.sv
// One storage cell of the list chain; holds a single entry.
`timescale 1ns / 1ps

module olir_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6,
    parameter int SW    = 32
) (
    input  logic                i_clk,
    input  olir_pkg::t_cell_act i_act,
    input  logic [IDX_W-1:0]    i_target,
    input  logic [SW-1:0]       i_item,
    input  logic [SW-1:0]       i_left,
    input  logic [SW-1:0]       i_right,
    output logic [SW-1:0]       o_data,
    output logic [SW-1:0]       o_tap
);
    import olir_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [SW-1:0] r_data;
    logic [SW-1:0] n_data;
    logic          w_hit;
    logic          w_above;

    assign w_hit   = (MY_IDX == i_target);
    assign w_above = (MY_IDX > i_target);

    // Insert pulls from the lower neighbor, remove pulls from the upper one.
    always_comb begin
        unique case (i_act)
            ACT_HOLD:       n_data = r_data;
            ACT_WRITE:      n_data = w_hit ? i_item : r_data;
            ACT_SHIFT_UP:   n_data = w_above ? i_left : (w_hit ? i_item : r_data);
            ACT_SHIFT_DOWN: n_data = (w_above || w_hit) ? i_right : r_data;
            default:        n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_hit ? r_data : '0;

endmodule

FILE: design/ordered_list_insert_remove_unit.sv
// Top level of the ordered list insert/remove unit: control, cell chain and read path.
`timescale 1ns / 1ps
//
//  Channel | Dir | Payload                          | Beat accepted when
//  --------+-----+----------------------------------+---------------------------
//  i_req   | in  | operation, position, item        | i_req.valid & i_req.ready
//  o_rsp   | out | ok, read_item, count             | o_rsp.valid & o_rsp.ready
//
//  One request is accepted per cycle while the output path is not stalled. The list
//  lives in a chain of CAPACITY cells, and every cell updates in the cycle a request
//  is accepted, so insert and remove move all later entries at once; the count
//  register is updated in that same cycle. A get is read through a two-level
//  registered OR tree over the cell taps, then sits in the output register.
//  A stalled output holds its beat; the stage before it keeps accepting until it is
//  also full. Reset clears the count and the pipeline valids; entry contents are
//  not cleared, since only positions below the count are ever read.

module ordered_list_insert_remove_unit #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    olir_stream_if.sink         i_req,
    olir_stream_if.source       o_rsp
);
    import olir_pkg::*;

    // Stored item width: the request field carries at most ITEM_W bits.
    localparam int SW    = (ITEM_WIDTH < ITEM_W) ? ITEM_WIDTH : ITEM_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam int NG    = (CAPACITY + TAP_GROUP - 1) / TAP_GROUP;

    // Count and handshake state.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_s1_valid;
    logic          r_s1_ok;
    logic          r_s1_get;
    logic [CW-1:0] r_s1_count;
    logic [SW-1:0] r_s1_part [NG];
    logic          r_out_valid;
    t_rsp          r_out;

    logic          w_fire;
    logic          w_s1_adv;
    logic          w_ok;
    logic          w_get;
    t_cell_act     w_act;
    logic [IDX_W-1:0] w_target;
    logic [CMP_W-1:0] w_pos_ext;
    logic [CMP_W-1:0] w_cnt_ext;
    logic          w_not_full;
    logic [SW-1:0] w_item;
    logic [SW-1:0] w_data [CAPACITY];
    logic [SW-1:0] w_tap  [NG*TAP_GROUP];
    logic [SW-1:0] w_part [NG];
    logic [SW-1:0] w_read;

    // The first stage moves on when the output register is free or being emptied.
    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || w_s1_adv;
    assign w_fire      = i_req.valid && i_req.ready;

    assign w_pos_ext  = CMP_W'(i_req.data.position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_not_full = (r_count < CW'(CAPACITY));
    assign w_item     = SW'(i_req.data.item);

    // Decode the request against the current count.
    always_comb begin
        w_ok    = 1'b0;
        w_get   = 1'b0;
        w_act   = ACT_HOLD;
        n_count = r_count;
        unique case (i_req.data.operation)
            OP_PUSH: begin
                w_ok    = w_not_full;
                w_act   = ACT_WRITE;
                n_count = r_count + CW'(1);
            end
            OP_INSERT: begin
                w_ok    = w_not_full && (w_pos_ext <= w_cnt_ext);
                w_act   = ACT_SHIFT_UP;
                n_count = r_count + CW'(1);
            end
            OP_POP: begin
                w_ok    = (r_count != '0);
                n_count = r_count - CW'(1);
            end
            OP_REMOVE: begin
                w_ok    = (w_pos_ext < w_cnt_ext);
                w_act   = ACT_SHIFT_DOWN;
                n_count = r_count - CW'(1);
            end
            OP_GET: begin
                w_ok  = (w_pos_ext < w_cnt_ext);
                w_get = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        // A refused or idle cycle leaves the list untouched.
        if (!(w_fire && w_ok)) begin
            w_act   = ACT_HOLD;
            n_count = r_count;
        end
    end

    // Push writes at the tail; insert, remove and get work at the given position, and pop only shrinks the count.
    assign w_target = (i_req.data.operation == OP_PUSH) ? IDX_W'(w_cnt_ext)
                                                        : IDX_W'(w_pos_ext);

    // The cell chain. Each cell sees its two neighbors; the first cell's lower input
    // is never selected, and the last cell's upper input is its own data.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [SW-1:0] w_left;
        logic [SW-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = w_item;
        end else begin : g_mid_l
            assign w_left = w_data[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = w_data[gi];
        end else begin : g_mid_r
            assign w_right = w_data[gi+1];
        end

        olir_cell #(
            .IDX   (gi),
            .IDX_W (IDX_W),
            .SW    (SW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_act    (w_act),
            .i_target (w_target),
            .i_item   (w_item),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_data   (w_data[gi]),
            .o_tap    (w_tap[gi])
        );
    end

    // Pad the tap row up to a whole number of groups.
    for (genvar gp = CAPACITY; gp < NG*TAP_GROUP; gp++) begin : g_pad
        assign w_tap[gp] = '0;
    end

    // First level of the read tree: only the addressed cell drives a nonzero tap.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_part[g] = '0;
            for (int k = 0; k < TAP_GROUP; k++) begin
                w_part[g] = w_part[g] | w_tap[g*TAP_GROUP + k];
            end
        end
    end

    // Second level of the read tree, from the registered group results.
    always_comb begin
        w_read = '0;
        for (int g = 0; g < NG; g++) begin
            w_read = w_read | r_s1_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1_ok    <= w_ok;
            r_s1_get   <= w_ok && w_get;
            r_s1_count <= n_count;
            for (int g = 0; g < NG; g++) begin
                r_s1_part[g] <= w_part[g];
            end
        end
        if (w_s1_adv) begin
            r_out.ok        <= r_s1_ok;
            r_out.read_item <= r_s1_get ? ITEM_W'(w_read) : '0;
            r_out.count     <= COUNT_W'(r_s1_count);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // The count can never pass the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count exceeds capacity");

    // A refused request leaves the count as it was.
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_ok) |=> $stable(r_count))
        else $error("refused request changed the count");

    // A successful push grows the list by exactly one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_ok && (i_req.data.operation == OP_PUSH))
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the count by one");

    // Only a successful response carries a read item.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.ok || (o_rsp.data.read_item == '0)))
        else $error("refused response carries a read item");

endmodule
